// File: hdl/rrtq_pkg.sv
`default_nettype none

package rrtq_pkg;

   // fixed field widths
   localparam int TASK_ID_W = 4;
   localparam int COUNT_W   = 5;

   // default number of task slots
   localparam int MAX_TASKS_DEFAULT = 16;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef logic [TASK_ID_W-1:0] task_id_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef enum logic [2:0] {
      CMD_CREATE  = 3'd0,
      CMD_SWITCH  = 3'd1,
      CMD_CHOOSE  = 3'd2,
      CMD_DESTROY = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ABSENT   = 2'd1,
      STATUS_EXISTS   = 2'd2,
      STATUS_NO_OTHER = 2'd3
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_CREATE,
      OP_SWITCH,
      OP_CHOOSE,
      OP_DESTROY,
      OP_CLEAR,
      OP_ABSENT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_APPEND,
      SEQ_READ,
      SEQ_REMOVE,
      SEQ_RESULT
   } seq_state_type;

   typedef struct packed {
      logic [2:0]  command;
      task_id_type task_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      task_id_type active_task;
      logic        current_valid;
      task_id_type chosen_task;
      logic        chosen_valid;
      count_type   queue_count;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      task_id_type task_id;
   } cmdq_entry_type;

endpackage

`default_nettype wire

// File: hdl/rrtq_ram.sv
`default_nettype none

module rrtq_ram #(
   parameter int WIDTH = rrtq_pkg::TASK_ID_W,
   parameter int DEPTH = rrtq_pkg::MAX_TASKS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/rrtq_front.sv
`default_nettype none

module rrtq_front #(
   parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output      logic                     req_full,
   input  wire rrtq_pkg::req_type        req_data,
   output      logic                     cmd_valid,
   output      rrtq_pkg::cmdq_entry_type cmd_entry,
   input  wire logic                     cmd_pop
);

   import rrtq_pkg::*;

   cmdq_entry_type          entries_ff [CMDQ_DEPTH];
   cmdq_entry_type          entry_in;
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    push_ok;
   logic                    in_range;

   // classify: ids beyond the slot range are absent for every command that names one
   always_comb begin
      in_range         = 32'(req_data.task_id) < MAX_TASKS;
      entry_in.task_id = req_data.task_id;
      unique case (req_data.command)
         CMD_CREATE:  entry_in.op = in_range ? OP_CREATE : OP_ABSENT;
         CMD_SWITCH:  entry_in.op = in_range ? OP_SWITCH : OP_ABSENT;
         CMD_DESTROY: entry_in.op = in_range ? OP_DESTROY : OP_ABSENT;
         CMD_CHOOSE:  entry_in.op = OP_CHOOSE;
         CMD_CLEAR:   entry_in.op = OP_CLEAR;
         default:     entry_in.op = OP_NOP;
      endcase
   end

   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_entry = entries_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, cmd_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rrtq_back.sv
`default_nettype none

module rrtq_back #(
   parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   input  wire rrtq_pkg::cmdq_entry_type cmd_entry,
   output      logic                     cmd_pop,
   input  wire logic                     slot_free,
   output      logic                     result_valid,
   output      rrtq_pkg::rsp_type        result
);

   import rrtq_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);

   seq_state_type          state_ff, state_in;
   logic [MAX_TASKS-1:0]   present_ff, present_in;
   task_id_type            head_ff, head_in;
   task_id_type            tail_ff, tail_in;
   count_type              count_ff, count_in;
   task_id_type            running_ff, running_in;
   logic                   running_valid_ff, running_valid_in;
   logic                   need_remove_ff, need_remove_in;
   logic                   make_running_ff, make_running_in;
   logic                   second_ff, second_in;

   status_type             status_ff, status_in;
   task_id_type            app_id_ff, app_id_in;
   task_id_type            rm_id_ff, rm_id_in;
   task_id_type            second_id_ff, second_id_in;

   logic [IDX_W-1:0]       idx;
   logic                   is_present;
   logic                   is_running;

   logic                   next_we, prev_we;
   logic [IDX_W-1:0]       next_waddr, prev_waddr;
   task_id_type            next_wdata, prev_wdata;
   task_id_type            next_rdata, prev_rdata;

   // links of the runnable list
   rrtq_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (IDX_W'(rm_id_ff)),
      .rd_data (next_rdata)
   );

   rrtq_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (IDX_W'(rm_id_ff)),
      .rd_data (prev_rdata)
   );

   assign idx        = IDX_W'(cmd_entry.task_id);
   assign is_present = present_ff[idx];
   assign is_running = running_valid_ff && (running_ff == cmd_entry.task_id);

   always_comb begin
      state_in         = state_ff;
      present_in       = present_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      count_in         = count_ff;
      running_in       = running_ff;
      running_valid_in = running_valid_ff;
      need_remove_in   = need_remove_ff;
      make_running_in  = make_running_ff;
      second_in        = second_ff;
      status_in        = status_ff;
      app_id_in        = app_id_ff;
      rm_id_in         = rm_id_ff;
      second_id_in     = second_id_ff;
      cmd_pop          = 1'b0;
      result_valid     = 1'b0;
      next_we          = 1'b0;
      prev_we          = 1'b0;
      next_waddr       = IDX_W'(tail_ff);
      prev_waddr       = IDX_W'(app_id_ff);
      next_wdata       = app_id_ff;
      prev_wdata       = tail_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop   = 1'b1;
               status_in = STATUS_OK;
               state_in  = SEQ_RESULT;
               unique case (cmd_entry.op)
                  OP_CREATE: begin
                     if (is_present) begin
                        status_in = STATUS_EXISTS;
                     end else begin
                        present_in[idx] = 1'b1;
                        app_id_in       = cmd_entry.task_id;
                        need_remove_in  = 1'b0;
                        state_in        = SEQ_APPEND;
                     end
                  end
                  OP_SWITCH: begin
                     if (!is_present) begin
                        status_in = STATUS_ABSENT;
                     end else if (!is_running) begin
                        rm_id_in        = cmd_entry.task_id;
                        make_running_in = 1'b1;
                        second_in       = 1'b0;
                        need_remove_in  = 1'b1;
                        app_id_in       = running_ff;
                        state_in        = running_valid_ff ? SEQ_APPEND : SEQ_READ;
                     end
                  end
                  OP_CHOOSE: begin
                     if (count_ff == '0 && !running_valid_ff) begin
                        status_in = STATUS_NO_OTHER;
                     end
                  end
                  OP_DESTROY: begin
                     if (!is_present) begin
                        status_in = STATUS_ABSENT;
                     end else if (is_running) begin
                        if (count_ff == '0) begin
                           status_in = STATUS_NO_OTHER;
                        end else begin
                           // switch to the head, then take the old task off the tail
                           present_in[idx] = 1'b0;
                           app_id_in       = cmd_entry.task_id;
                           rm_id_in        = head_ff;
                           make_running_in = 1'b1;
                           second_in       = 1'b1;
                           second_id_in    = cmd_entry.task_id;
                           need_remove_in  = 1'b1;
                           state_in        = SEQ_APPEND;
                        end
                     end else begin
                        present_in[idx] = 1'b0;
                        rm_id_in        = cmd_entry.task_id;
                        make_running_in = 1'b0;
                        second_in       = 1'b0;
                        state_in        = SEQ_READ;
                     end
                  end
                  OP_CLEAR: begin
                     present_in       = '0;
                     head_in          = '0;
                     tail_in          = '0;
                     count_in         = '0;
                     running_in       = '0;
                     running_valid_in = 1'b0;
                  end
                  OP_ABSENT: begin
                     status_in = STATUS_ABSENT;
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         SEQ_APPEND: begin
            if (count_ff != '0) begin
               next_we = 1'b1;
               prev_we = 1'b1;
            end else begin
               head_in = app_id_ff;
            end
            tail_in  = app_id_ff;
            count_in = count_ff + 1'b1;
            state_in = need_remove_ff ? SEQ_READ : SEQ_RESULT;
         end

         // link data for rm_id_ff comes out of the rams in the next cycle
         SEQ_READ: begin
            state_in = SEQ_REMOVE;
         end

         SEQ_REMOVE: begin
            next_waddr = IDX_W'(prev_rdata);
            next_wdata = next_rdata;
            prev_waddr = IDX_W'(next_rdata);
            prev_wdata = prev_rdata;
            if (count_ff <= COUNT_W'(1)) begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end else begin
               if (rm_id_ff == head_ff) begin
                  head_in = next_rdata;
               end else begin
                  next_we = 1'b1;
               end
               if (rm_id_ff == tail_ff) begin
                  tail_in = prev_rdata;
               end else begin
                  prev_we = 1'b1;
               end
               count_in = count_ff - 1'b1;
            end
            if (make_running_ff) begin
               running_in       = rm_id_ff;
               running_valid_in = 1'b1;
            end
            if (second_ff) begin
               rm_id_in        = second_id_ff;
               second_in       = 1'b0;
               make_running_in = 1'b0;
               state_in        = SEQ_READ;
            end else begin
               state_in = SEQ_RESULT;
            end
         end

         SEQ_RESULT: begin
            result_valid = 1'b1;
            state_in     = SEQ_IDLE;
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      result.status        = status_ff;
      result.active_task   = running_valid_ff ? running_ff : '0;
      result.current_valid = running_valid_ff;
      result.queue_count   = count_ff;
      if (count_ff != '0) begin
         result.chosen_task  = head_ff;
         result.chosen_valid = 1'b1;
      end else begin
         result.chosen_task  = running_valid_ff ? running_ff : '0;
         result.chosen_valid = running_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= SEQ_IDLE;
         present_ff       <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         count_ff         <= '0;
         running_ff       <= '0;
         running_valid_ff <= 1'b0;
         need_remove_ff   <= 1'b0;
         make_running_ff  <= 1'b0;
         second_ff        <= 1'b0;
      end else begin
         state_ff         <= state_in;
         present_ff       <= present_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         count_ff         <= count_in;
         running_ff       <= running_in;
         running_valid_ff <= running_valid_in;
         need_remove_ff   <= need_remove_in;
         make_running_ff  <= make_running_in;
         second_ff        <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      app_id_ff    <= app_id_in;
      rm_id_ff     <= rm_id_in;
      second_id_ff <= second_id_in;
   end

endmodule

`default_nettype wire

// File: hdl/round_robin_task_queue_top.sv
// Run queue for a round-robin task scheduler. Commands enter through a queue-style
// port (req_push / req_full) and each one produces exactly one result on the
// response side (rsp_empty / rsp_pop), in command order. A front stage classifies
// each command and holds up to two of them, so new commands are taken while the
// back stage works or while a result waits to be popped. The back stage keeps a
// present bit per task slot, the running task, and the runnable list as a doubly
// linked list in two small rams with registered reads. A command that only reports
// (choose, clear all, switch to the running task, refused commands) goes straight
// to the result state; a create appends one list entry; destroying a waiting task
// or a switch while nothing runs removes one entry; a switch that sends a running
// task back to the list appends it and then removes the target task; destroying
// the running task appends it, removes the head and then removes the old task.
// Each list removal is a ram read followed by a write. The result then passes
// through the result register. There is no clearing pass after reset: a link is
// only used where it was written while the task was queued.
`default_nettype none

module round_robin_task_queue_top #(
   parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // command side
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire rrtq_pkg::req_type req_data,
   // result side
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      rrtq_pkg::rsp_type rsp_data
);

   import rrtq_pkg::*;

   // front to back
   logic           cmd_valid;
   cmdq_entry_type cmd_entry;
   logic           cmd_pop;

   // back to result register
   logic           result_valid;
   rsp_type        result;
   logic           slot_free;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;

   // front: decode command code and id range, buffer the transfer
   rrtq_front #(.MAX_TASKS(MAX_TASKS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_entry (cmd_entry),
      .cmd_pop   (cmd_pop)
   );

   // back: list sequencer, owns all scheduler state
   rrtq_back #(.MAX_TASKS(MAX_TASKS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_entry    (cmd_entry),
      .cmd_pop      (cmd_pop),
      .slot_free    (slot_free),
      .result_valid (result_valid),
      .result       (result)
   );

   // back starts a command only when the result slot is empty, so a finished
   // result never overwrites one that is still waiting
   assign slot_free = !rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      if (result_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded once per command
   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a new result only lands in an empty slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> !rsp_valid_ff)
      else $error("result written while previous result still waiting");

   // something is chosen exactly when a task runs or waits
   a_chosen_consistent: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.chosen_valid ==
                      (rsp_data.current_valid || (rsp_data.queue_count != '0))))
      else $error("chosen_valid disagrees with running and waiting tasks");

   // the waiting list never holds more tasks than there are slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_data.queue_count) <= MAX_TASKS))
      else $error("queue count beyond the number of task slots");
`endif

endmodule

`default_nettype wire
